[hdl/rtce_pkg.sv]
// ----------------------------------------------------------------------------
// RTC register decode package
// Types, constants and small helper functions shared by the RTC register to
// epoch seconds converter and its channel interfaces.
// ----------------------------------------------------------------------------
package rtce_pkg;

	localparam int RAW_W   = 8;
	localparam int EPOCH_W = 33;
	localparam int YEAR_W  = 12;
	localparam int DOY_W   = 9;
	localparam int YOE_W   = 9;
	localparam int DOE_W   = 18;
	localparam int DAYS_W  = 17;
	localparam int SOD_W   = 17;

	localparam logic [YEAR_W-1:0] YEAR_MIN   = 12'd1970;
	localparam logic [YEAR_W-1:0] YEAR_MAX   = 12'd2199;
	localparam logic [YEAR_W-1:0] ERA5_START = 12'd2000;
	localparam logic [YEAR_W-1:0] ERA4_START = 12'd1600;

	// Offsets from the start of the era to the epoch, folded into one bias per era.
	localparam logic [DOE_W-1:0] ERA5_BIAS = 18'd11017;
	localparam logic [DOE_W-1:0] ERA4_BIAS = 18'd135080;

	localparam logic [SOD_W-1:0] SEC_PER_HOUR = 17'd3600;
	localparam logic [SOD_W-1:0] SEC_PER_MIN  = 17'd60;
	localparam logic [33:0]      SEC_PER_DAY  = 34'd86400;

	localparam logic [EPOCH_W-1:0] EPOCH_MAX = 33'd7258118399;

	typedef enum logic [0:0] {
		REG_BINARY_MODE = 1'b0,
		REG_HOUR24_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic binary_mode;
		logic hour24_mode;
	} cfg_t;

	typedef struct packed {
		logic [RAW_W-1:0]  sec;
		logic [RAW_W-1:0]  min;
		logic [RAW_W-1:0]  hour;
		logic              pm;
		logic              h12;
		logic [RAW_W-1:0]  day;
		logic [RAW_W-1:0]  month;
		logic [YEAR_W-1:0] year;
	} dec_t;

	function automatic logic [RAW_W-1:0] bcd_value(input logic [RAW_W-1:0] v);
		logic [RAW_W-1:0] tens;
		tens = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0};
		return tens + {4'b0000, v[3:0]};
	endfunction

	// Remainder by twelve for values below 128, via a reciprocal multiply.
	function automatic logic [3:0] mod12(input logic [6:0] h);
		logic [14:0] p;
		logic [6:0]  r;
		p = 15'(h) * 15'd171;
		r = h - 7'(p[14:11]) * 7'd12;
		return r[3:0];
	endfunction

	// Day of the March-based year on which the given month starts.
	function automatic logic [DOY_W-1:0] month_offset(input logic [RAW_W-1:0] month);
		logic [DOY_W-1:0] off;
		case (month)
			8'd3:    off = 9'd0;
			8'd4:    off = 9'd31;
			8'd5:    off = 9'd61;
			8'd6:    off = 9'd92;
			8'd7:    off = 9'd122;
			8'd8:    off = 9'd153;
			8'd9:    off = 9'd184;
			8'd10:   off = 9'd214;
			8'd11:   off = 9'd245;
			8'd12:   off = 9'd275;
			8'd1:    off = 9'd306;
			8'd2:    off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

[hdl/rtce_if.sv]
// ----------------------------------------------------------------------------
// RTC converter channels
// Valid/ready channels for the raw register snapshot and the epoch result.
// ----------------------------------------------------------------------------
interface rtce_snap_if import rtce_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_seconds;
	logic [RAW_W-1:0] raw_minutes;
	logic [RAW_W-1:0] raw_hours;
	logic [RAW_W-1:0] raw_day;
	logic [RAW_W-1:0] raw_month;
	logic [RAW_W-1:0] raw_year;
	logic [RAW_W-1:0] raw_century;

	modport source (
		output valid, raw_seconds, raw_minutes, raw_hours, raw_day, raw_month,
		       raw_year, raw_century,
		input  ready
	);
	modport sink (
		input  valid, raw_seconds, raw_minutes, raw_hours, raw_day, raw_month,
		       raw_year, raw_century,
		output ready
	);
endinterface

interface rtce_epoch_if import rtce_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EPOCH_W-1:0] epoch_seconds;
	logic               date_valid;

	modport source (output valid, epoch_seconds, date_valid, input ready);
	modport sink (input valid, epoch_seconds, date_valid, output ready);
endinterface

[hdl/rtce_decode.sv]
// ----------------------------------------------------------------------------
// RTC field decode
// Turns raw register bytes into binary field values and a four-digit year.
// ----------------------------------------------------------------------------
module rtce_decode import rtce_pkg::*; (
	input  cfg_t             cfg,
	input  logic [RAW_W-1:0] raw_seconds,
	input  logic [RAW_W-1:0] raw_minutes,
	input  logic [RAW_W-1:0] raw_hours,
	input  logic [RAW_W-1:0] raw_day,
	input  logic [RAW_W-1:0] raw_month,
	input  logic [RAW_W-1:0] raw_year,
	input  logic [RAW_W-1:0] raw_century,
	output dec_t             dec
);

	logic [RAW_W-1:0] hour_byte;
	logic [RAW_W-1:0] year2;
	logic [RAW_W-1:0] cent;

	always_comb begin
		// In 12-hour mode the PM flag is stripped before the hour is decoded.
		hour_byte = cfg.hour24_mode ? raw_hours : {1'b0, raw_hours[6:0]};
		dec.pm    = raw_hours[7];
		dec.h12   = !cfg.hour24_mode;
		if (cfg.binary_mode) begin
			dec.sec   = raw_seconds;
			dec.min   = raw_minutes;
			dec.hour  = hour_byte;
			dec.day   = raw_day;
			dec.month = raw_month;
			year2     = raw_year;
			cent      = raw_century;
		end else begin
			dec.sec   = bcd_value(raw_seconds);
			dec.min   = bcd_value(raw_minutes);
			dec.hour  = bcd_value(hour_byte);
			dec.day   = bcd_value(raw_day);
			dec.month = bcd_value(raw_month);
			year2     = bcd_value(raw_year);
			cent      = bcd_value(raw_century);
		end
		if (cent >= 8'd19 && cent <= 8'd21) begin
			dec.year = 12'(cent) * 12'd100 + 12'(year2);
		end else if (year2 < 8'd70) begin
			dec.year = 12'd2000 + 12'(year2);
		end else begin
			dec.year = 12'd1900 + 12'(year2);
		end
	end

endmodule

[hdl/rtc_registers_to_epoch_seconds.sv]
// ----------------------------------------------------------------------------
// RTC registers to epoch seconds
// Converts a snapshot of clock-chip date and time registers into Unix seconds.
// ----------------------------------------------------------------------------
// The converter takes one snapshot per clock cycle while snap.ready is high
// and returns its result through an output register after four pipeline
// stages (field decode, range check and calendar split, day count, and the
// multiply by the length of a day). A stall on the result side holds each
// stage only while the stage after it is full, so empty stages keep filling.
// Dates failing the range check give a zero epoch with date_valid low. The
// mode registers should only be written while no snapshot is in flight.
module rtc_registers_to_epoch_seconds import rtce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	rtce_snap_if.sink         snap,
	rtce_epoch_if.source      result
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;

	dec_t dec;
	dec_t dec_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [YEAR_W-1:0] year_adj;
	logic [YEAR_W-1:0] yoe_wide;
	logic [4:0]        hour_fix;
	logic              era5;
	logic              range_ok;

	logic              ok_s2;
	logic [4:0]        hour_s2;
	logic [5:0]        min_s2;
	logic [5:0]        sec_s2;
	logic              era5_s2;
	logic [YOE_W-1:0]  yoe_s2;
	logic [DOY_W-1:0]  doy_s2;

	logic [14:0]       div100_p;
	logic [DOE_W-1:0]  doe;
	logic [DOE_W-1:0]  days_w;
	logic [SOD_W-1:0]  sod;

	logic              ok_s3;
	logic [DAYS_W-1:0] days_s3;
	logic [SOD_W-1:0]  sod_s3;

	logic [33:0]        day_prod;
	logic [EPOCH_W-1:0] epoch_s4;
	logic               ok_s4;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.binary_mode <= 1'b0;
			cfg_q.hour24_mode <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_BINARY_MODE: cfg_q.binary_mode <= pwdata[0];
				REG_HOUR24_MODE: cfg_q.hour24_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BINARY_MODE: prdata = {31'b0, cfg_q.binary_mode};
			REG_HOUR24_MODE: prdata = {31'b0, cfg_q.hour24_mode};
			default:         prdata = '0;
		endcase
	end

	// Pipeline flow control.
	assign rdy4       = !v_s4 || result.ready;
	assign rdy3       = !v_s3 || rdy4;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign snap.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= snap.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: field decode.
	rtce_decode u_decode (
		.cfg         (cfg_q),
		.raw_seconds (snap.raw_seconds),
		.raw_minutes (snap.raw_minutes),
		.raw_hours   (snap.raw_hours),
		.raw_day     (snap.raw_day),
		.raw_month   (snap.raw_month),
		.raw_year    (snap.raw_year),
		.raw_century (snap.raw_century),
		.dec         (dec)
	);

	always_ff @(posedge clk) begin
		if (rdy1 && snap.valid) begin
			dec_s1 <= dec;
		end
	end

	// Stage 2: hour fix-up, range checks and the split of the year into era
	// and year of era, counted from March.
	always_comb begin
		if (dec_s1.h12) begin
			hour_fix = 5'(mod12(dec_s1.hour[6:0])) + (dec_s1.pm ? 5'd12 : 5'd0);
		end else begin
			hour_fix = dec_s1.hour[4:0];
		end
		range_ok = dec_s1.sec <= 8'd59 && dec_s1.min <= 8'd59 &&
		           (dec_s1.h12 || dec_s1.hour <= 8'd23) &&
		           dec_s1.day >= 8'd1 && dec_s1.day <= 8'd31 &&
		           dec_s1.month >= 8'd1 && dec_s1.month <= 8'd12 &&
		           dec_s1.year >= YEAR_MIN && dec_s1.year <= YEAR_MAX;
		year_adj = dec_s1.year - ((dec_s1.month <= 8'd2) ? 12'd1 : 12'd0);
		era5     = year_adj >= ERA5_START;
		yoe_wide = year_adj - (era5 ? ERA5_START : ERA4_START);
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ok_s2   <= range_ok;
			hour_s2 <= hour_fix;
			min_s2  <= dec_s1.min[5:0];
			sec_s2  <= dec_s1.sec[5:0];
			era5_s2 <= era5;
			yoe_s2  <= yoe_wide[YOE_W-1:0];
			doy_s2  <= month_offset(dec_s1.month) + 9'(dec_s1.day) - 9'd1;
		end
	end

	// Stage 3: day count from the epoch and seconds of the day.
	always_comb begin
		div100_p = 15'(yoe_s2) * 15'd41;
		doe      = 18'(yoe_s2) * 18'd365 + 18'(yoe_s2[YOE_W-1:2]) -
		           18'(div100_p[14:12]) + 18'(doy_s2);
		days_w   = era5_s2 ? doe + ERA5_BIAS : doe - ERA4_BIAS;
		sod      = 17'(hour_s2) * SEC_PER_HOUR + 17'(min_s2) * SEC_PER_MIN +
		           17'(sec_s2);
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			ok_s3   <= ok_s2;
			days_s3 <= days_w[DAYS_W-1:0];
			sod_s3  <= sod;
		end
	end

	// Stage 4: days times the length of a day, plus the time of day.
	assign day_prod = 34'(days_s3) * SEC_PER_DAY;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			ok_s4    <= ok_s3;
			epoch_s4 <= ok_s3 ? day_prod[EPOCH_W-1:0] + 33'(sod_s3) : '0;
		end
	end

	assign result.valid         = v_s4;
	assign result.epoch_seconds = epoch_s4;
	assign result.date_valid    = ok_s4;

	// An invalid date always comes out as zero seconds.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.date_valid |-> result.epoch_seconds == '0)
		else $error("invalid date with nonzero epoch");

	// A valid date never lies beyond the end of 2199.
	a_epoch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.date_valid |-> result.epoch_seconds <= EPOCH_MAX)
		else $error("epoch beyond supported range");

	// The input is held off only when every stage holds an item.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!snap.ready |-> v_s1 && v_s2 && v_s3 && v_s4)
		else $error("input stalled with an empty stage");

	// An item held in the last stage stays there until it is taken.
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !result.ready |=> v_s4 && $stable(epoch_s4) && $stable(ok_s4))
		else $error("stalled result lost or changed");

endmodule
